[sv/tpq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpq_pkg
// Types, status codes and ordering function for the task priority queue.
// ----------------------------------------------------------------------------
package tpq_pkg;

  localparam int unsigned OCC_W = 6;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK         = 2'd0;
  localparam status_t ST_POP_EMPTY  = 2'd1;
  localparam status_t ST_INS_FULL   = 2'd2;

  typedef struct packed {
    logic [7:0]  prio;
    logic [23:0] rtime;
    logic [15:0] task_id;
  } key_t;

  typedef struct packed {
    logic [7:0]  thread_id;
    logic [23:0] start_time;
  } payload_t;

  typedef struct packed {
    key_t     key;
    payload_t pl;
  } rec_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_WALK,
    S_INS_PUT,
    S_POP_DATA,
    S_DONE
  } state_t;

  // a strictly ahead of b: higher priority, then less time left, then lower id
  function automatic logic precedes(input key_t a, input key_t b);
    logic r;
    if (a.prio != b.prio)        r = (a.prio > b.prio);
    else if (a.rtime != b.rtime) r = (a.rtime < b.rtime);
    else                         r = (a.task_id < b.task_id);
    return r;
  endfunction

endpackage
`default_nettype wire

[sv/task_priority_queue_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// task_priority_queue_unit
// Bounded task queue kept sorted in a single synchronous RAM.
// ----------------------------------------------------------------------------
// Each input beat is either an insert of a task record (in_tuser = 0) or a
// pop of the head (in_tuser = 1), and gives exactly one output beat. Order is
// higher priority first, then smaller remaining time, then smaller id; a new
// task lands ahead of any equal key. The records sit in one RAM used as a
// ring: a head pointer makes pop cheap, and an insert walks from the tail
// towards the head, moving one record up per cycle until its slot is found.
// From acceptance to the output register, an insert walks (one RAM read and
// one RAM write per cycle; no walk into an empty queue), places the task in
// S_INS_PUT if it reaches the head, then loads the result in S_DONE; a pop
// takes the head record in S_POP_DATA, then loads the result; a full insert
// or an empty pop goes straight to S_DONE. S_DONE waits while the output
// register is stalled, then returns to S_IDLE before the next beat is taken.
// The slowest beat is an insert into a queue of QUEUE_DEPTH - 1 tasks.
// One beat is in flight at a time; a new beat is taken while the previous
// result still waits in the output register. Status on out_tuser: 0 ok,
// 1 pop on empty, 2 insert on full (task dropped). Task fields of the result
// are zero except on a successful pop. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module task_priority_queue_unit
  import tpq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata from bit 0: task_id[16], priority_req[8], time_left[24],
  // thread_id[8], start_time[24]
  input  wire logic [79:0] in_tdata,
  // in_tuser: cmd[1] (0 insert, 1 pop)
  input  wire logic [0:0]  in_tuser,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // out_tdata from bit 0: out_task_id[16], out_priority[8],
  // out_time_left[24], out_thread_id[8], out_start_time[24],
  // occupancy[6], zero pad[2]
  output logic [87:0]      out_tdata,
  // out_tuser: status[2]
  output logic [1:0]       out_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW:0]   DEPTH_W = (AW+1)'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  // ring address: head plus offset, wrapped once
  function automatic logic [AW-1:0] ring(input logic [AW-1:0] h, input logic [AW-1:0] l);
    logic [AW:0] s;
    s = {1'b0, h} + {1'b0, l};
    if (s >= DEPTH_W) s = s - DEPTH_W;
    return s[AW-1:0];
  endfunction

  // record store
  rec_t mem [QUEUE_DEPTH];
  rec_t            rdata_r;
  logic            mem_we;
  logic [AW-1:0]   mem_wa;
  logic [AW-1:0]   mem_ra;
  rec_t            mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_r <= mem[mem_ra];
  end

  // control and bookkeeping
  state_t          state_r, state_nxt;
  logic [AW-1:0]   head_r, head_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;
  rec_t            new_r, new_nxt;
  status_t         res_status_r, res_status_nxt;
  rec_t            res_rec_r, res_rec_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [87:0]     out_data_r, out_data_nxt;
  logic [1:0]      out_user_r, out_user_nxt;

  rec_t            in_rec;
  logic            in_acc;
  logic            is_full;
  logic            is_empty;
  logic            hit;
  logic            out_free;
  logic [OCC_W+CW-1:0] occ_ext;

  assign in_rec.key.task_id  = in_tdata[15:0];
  assign in_rec.key.prio     = in_tdata[23:16];
  assign in_rec.key.rtime    = in_tdata[47:24];
  assign in_rec.pl.thread_id = in_tdata[55:48];
  assign in_rec.pl.start_time = in_tdata[79:56];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign is_full   = (count_r >= DEPTH_C);
  assign is_empty  = (count_r == '0);
  assign hit       = precedes(rdata_r.key, new_r.key);
  assign out_free  = !out_valid_r || out_tready;
  assign occ_ext   = {{OCC_W{1'b0}}, count_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser[0]) state_nxt = is_empty ? S_DONE : S_POP_DATA;
          else if (is_full) state_nxt = S_DONE;
          else if (is_empty) state_nxt = S_INS_PUT;
          else state_nxt = S_INS_WALK;
        end
      end
      S_INS_WALK: begin
        if (hit) state_nxt = S_DONE;
        else if (idx_r == AW'(1)) state_nxt = S_INS_PUT;
      end
      S_INS_PUT:  state_nxt = S_DONE;
      S_POP_DATA: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    mem_we         = 1'b0;
    mem_wa         = ring(head_r, idx_r);
    mem_wd         = new_r;
    mem_ra         = ring(head_r, idx_r - AW'(2));
    head_nxt       = head_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    new_nxt        = new_r;
    res_status_nxt = res_status_r;
    res_rec_nxt    = res_rec_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;
    unique case (state_r)
      S_IDLE: begin
        // tail record read ahead for an insert, head record for a pop
        mem_ra = in_tuser[0] ? head_r : ring(head_r, AW'(count_r - CW'(1)));
        if (in_acc) begin
          new_nxt        = in_rec;
          idx_nxt        = is_empty ? '0 : AW'(count_r);
          res_rec_nxt    = '0;
          res_status_nxt = ST_OK;
          if (in_tuser[0] && is_empty) res_status_nxt = ST_POP_EMPTY;
          if (!in_tuser[0] && is_full) res_status_nxt = ST_INS_FULL;
        end
      end
      S_INS_WALK: begin
        // rdata_r is the record at offset idx_r - 1
        mem_we = 1'b1;
        if (hit) begin
          count_nxt = count_r + CW'(1);
        end else begin
          mem_wd  = rdata_r;
          idx_nxt = idx_r - AW'(1);
        end
      end
      S_INS_PUT: begin
        mem_we    = 1'b1;
        count_nxt = count_r + CW'(1);
      end
      S_POP_DATA: begin
        res_rec_nxt = rdata_r;
        head_nxt    = ring(head_r, AW'(1));
        count_nxt   = count_r - CW'(1);
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = res_status_r;
          out_data_nxt  = {2'b00, occ_ext[OCC_W-1:0],
                           res_rec_r.pl.start_time, res_rec_r.pl.thread_id,
                           res_rec_r.key.rtime, res_rec_r.key.prio,
                           res_rec_r.key.task_id};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    new_r        <= new_nxt;
    res_status_r <= res_status_nxt;
    res_rec_r    <= res_rec_nxt;
    out_data_r   <= out_data_nxt;
    out_user_r   <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
`default_nettype wire
